[sv/sarl_pkg.sv]
package sarl_pkg;

  localparam int unsigned MAX_REGIONS_DEFAULT = 256;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned TAG_W = 16;
  localparam int unsigned ENTRY_COUNT_W = 9;
  localparam int unsigned STATUS_W = 2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] e;
    logic [TAG_W-1:0] t;
  } entry_t;

  typedef enum logic [3:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SORT_EVEN,
    OP_SORT_ODD,
    OP_MARK,
    OP_PACK_EVEN,
    OP_PACK_ODD,
    OP_PROBE,
    OP_SELECT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic [ADDR_W-1:0] key;
    entry_t data;
  } cell_ctrl_t;

  // true when a must come after b in (start, end) order
  function automatic logic comes_after(entry_t a, entry_t b);
    logic r;
    if (a.s != b.s) r = a.s > b.s;
    else r = a.e > b.e;
    return r;
  endfunction

endpackage

[sv/sorted_address_range_lookup.sv]
// Region table with lookup by address.
// Input channel s_*: s_tuser is the command (insert or lookup); s_tdata carries
// start, exclusive end and tag of a region to insert, and the address to look up.
// Output channel m_*: one response per request; m_tuser is the status (ok/hit,
// miss, full), m_tdata the matched region and the number of regions held.
// An insert answers in the next cycle. A lookup on a clean table first probes
// every entry cell against the address, then runs a binary search, one step per
// cycle over the row of entry cells. The first lookup after inserts first runs
// an odd-even transposition sort, an overlap mark, odd-even compaction passes
// and a binary search for the new count.
// One request is in flight at a time; s_tready is high only while idle and the
// response register is free or being emptied. A stalled m_tready holds the
// response and blocks further requests. Reset empties the table (count zero).
module sorted_address_range_lookup #(
  parameter int unsigned MAX_REGIONS = sarl_pkg::MAX_REGIONS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic s_tuser,            // cmd
  input  logic [207:0] s_tdata,    // start_addr, end_addr, region_tag, lookup_addr
  output logic m_tvalid,
  input  logic m_tready,
  output logic [1:0] m_tuser,      // status
  output logic [159:0] m_tdata     // hit_start, hit_end, hit_tag, entry_count, zero fill
);

  localparam int unsigned IW = $clog2(MAX_REGIONS);
  localparam int unsigned CW = $clog2(MAX_REGIONS+1);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_SORT    = 9'b000000010,
    ST_MARK    = 9'b000000100,
    ST_PACK    = 9'b000001000,
    ST_COUNT   = 9'b000010000,
    ST_PROBE   = 9'b000100000,
    ST_SEARCH  = 9'b001000000,
    ST_GATHER  = 9'b010000000,
    ST_DONE    = 9'b100000000
  } state_t;

  state_t state;
  logic [CW-1:0] count, pass, lo, hi;
  logic needs_sort, phase, found;
  logic [IW-1:0] idx;
  logic [sarl_pkg::ADDR_W-1:0] key;

  sarl_pkg::cell_ctrl_t ctrl;
  logic [IW-1:0] sel;
  sarl_pkg::entry_t ent_arr [MAX_REGIONS];
  sarl_pkg::entry_t pick_arr [MAX_REGIONS];
  logic [MAX_REGIONS-1:0] drop_vec, kept_vec, lt_vec, ge_vec;
  sarl_pkg::entry_t hit;

  logic [CW:0] mid_w;
  logic [IW-1:0] mid;
  logic pass_done, accept, resp_load;
  sarl_pkg::entry_t in_ent;

  genvar g;
  generate
    for (g = 0; g < MAX_REGIONS; g++) begin : g_cell
      sarl_pkg::entry_t l_ent, r_ent;
      logic l_drop, r_drop;
      if (g == 0) begin : g_first
        assign l_ent = '0;
        assign l_drop = 1'b0;
      end else begin : g_mid_l
        assign l_ent = ent_arr[g-1];
        assign l_drop = drop_vec[g-1];
      end
      if (g == MAX_REGIONS - 1) begin : g_last
        assign r_ent = '0;
        assign r_drop = 1'b0;
      end else begin : g_mid_r
        assign r_ent = ent_arr[g+1];
        assign r_drop = drop_vec[g+1];
      end
      sarl_cell #(.IDX(g), .MAX_REGIONS(MAX_REGIONS)) u_cell (
        .clk(clk), .ctrl(ctrl), .count(count), .sel(sel),
        .left_ent(l_ent), .left_drop(l_drop),
        .right_ent(r_ent), .right_drop(r_drop),
        .ent(ent_arr[g]), .drop(drop_vec[g]), .kept(kept_vec[g]),
        .lt(lt_vec[g]), .ge(ge_vec[g]), .pick(pick_arr[g])
      );
    end
  endgenerate

  always_comb begin
    hit = '0;
    for (int i = 0; i < MAX_REGIONS; i++) hit = hit | pick_arr[i];
  end

  always_comb begin
    accept = s_tvalid && s_tready;
    in_ent.s = s_tdata[63:0];
    in_ent.e = s_tdata[127:64];
    in_ent.t = s_tdata[143:128];
    mid_w = ((CW+1)'(lo) + (CW+1)'(hi)) >> 1;
    mid = IW'(mid_w);
    pass_done = ((CW+1)'(pass) + (CW+1)'(1)) >= (CW+1)'(count);
    s_tready = (state == ST_IDLE) && (!m_tvalid || m_tready);
    resp_load = (state == ST_DONE) ||
                ((state == ST_IDLE) && accept && s_tuser == sarl_pkg::CMD_INSERT);
    ctrl.key = key;
    ctrl.data = in_ent;
    ctrl.op = sarl_pkg::OP_HOLD;
    sel = idx;
    unique case (state)
      ST_IDLE: begin
        sel = IW'(count);
        if (accept && s_tuser == sarl_pkg::CMD_INSERT && count != CW'(MAX_REGIONS))
          ctrl.op = sarl_pkg::OP_LOAD;
      end
      ST_SORT: ctrl.op = phase ? sarl_pkg::OP_SORT_ODD : sarl_pkg::OP_SORT_EVEN;
      ST_MARK: ctrl.op = sarl_pkg::OP_MARK;
      ST_PACK: ctrl.op = phase ? sarl_pkg::OP_PACK_ODD : sarl_pkg::OP_PACK_EVEN;
      ST_PROBE: ctrl.op = sarl_pkg::OP_PROBE;
      ST_GATHER: ctrl.op = sarl_pkg::OP_SELECT;
      default: ctrl.op = sarl_pkg::OP_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      needs_sort <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (resp_load) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser == sarl_pkg::CMD_INSERT) begin
              if (count == CW'(MAX_REGIONS)) begin
                m_tuser <= sarl_pkg::STATUS_FULL;
                m_tdata <= {7'd0, sarl_pkg::ENTRY_COUNT_W'(count), 144'd0};
              end else begin
                m_tuser <= sarl_pkg::STATUS_OK;
                m_tdata <= {7'd0, sarl_pkg::ENTRY_COUNT_W'(count + CW'(1)), 144'd0};
                count <= count + CW'(1);
                needs_sort <= 1'b1;
              end
            end else begin
              key <= s_tdata[207:144];
              pass <= '0;
              phase <= 1'b0;
              if (needs_sort) begin
                needs_sort <= 1'b0;
                state <= ST_SORT;
              end else begin
                state <= ST_PROBE;
              end
            end
          end
        end
        ST_SORT: begin
          phase <= !phase;
          pass <= pass + CW'(1);
          if (pass_done) state <= ST_MARK;
        end
        ST_MARK: begin
          pass <= '0;
          phase <= 1'b0;
          state <= ST_PACK;
        end
        ST_PACK: begin
          phase <= !phase;
          pass <= pass + CW'(1);
          if (pass_done) begin
            lo <= '0;
            hi <= count;
            state <= ST_COUNT;
          end
        end
        ST_COUNT: begin
          // kept entries form a prefix, find its length
          if (lo < hi) begin
            if (kept_vec[mid]) lo <= CW'(mid) + CW'(1);
            else hi <= CW'(mid);
          end else begin
            count <= lo;
            state <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          lo <= '0;
          hi <= count;
          found <= 1'b0;
          state <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (lo < hi) begin
            if (lt_vec[mid]) hi <= CW'(mid);
            else if (ge_vec[mid]) lo <= CW'(mid) + CW'(1);
            else begin
              found <= 1'b1;
              idx <= mid;
              state <= ST_GATHER;
            end
          end else begin
            state <= ST_DONE;
          end
        end
        ST_GATHER: state <= ST_DONE;
        ST_DONE: begin
          if (found) begin
            m_tuser <= sarl_pkg::STATUS_OK;
            m_tdata <= {7'd0, sarl_pkg::ENTRY_COUNT_W'(count), hit.t, hit.e, hit.s};
          end else begin
            m_tuser <= sarl_pkg::STATUS_MISS;
            m_tdata <= {7'd0, sarl_pkg::ENTRY_COUNT_W'(count), 144'd0};
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[sv/sarl_cell.sv]
module sarl_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned MAX_REGIONS = sarl_pkg::MAX_REGIONS_DEFAULT
) (
  input  logic clk,
  input  sarl_pkg::cell_ctrl_t ctrl,
  input  logic [$clog2(MAX_REGIONS+1)-1:0] count,
  input  logic [$clog2(MAX_REGIONS)-1:0] sel,
  input  sarl_pkg::entry_t left_ent,
  input  logic left_drop,
  input  sarl_pkg::entry_t right_ent,
  input  logic right_drop,
  output sarl_pkg::entry_t ent,
  output logic drop,
  output logic kept,
  output logic lt,
  output logic ge,
  output sarl_pkg::entry_t pick
);

  localparam int unsigned IW = $clog2(MAX_REGIONS);
  localparam int unsigned CW = $clog2(MAX_REGIONS+1);
  localparam bit EVEN = (IDX % 2) == 0;
  localparam bit HAS_LEFT = IDX > 0;

  logic mine_valid, right_valid, is_odd, is_pack;
  logic role_left, role_right, swap_r, swap_l;

  always_comb begin
    mine_valid = CW'(IDX) < count;
    right_valid = CW'(IDX + 1) < count;
    is_odd = (ctrl.op == sarl_pkg::OP_SORT_ODD) || (ctrl.op == sarl_pkg::OP_PACK_ODD);
    is_pack = (ctrl.op == sarl_pkg::OP_PACK_EVEN) || (ctrl.op == sarl_pkg::OP_PACK_ODD);
    role_left = is_odd ? !EVEN : EVEN;
    role_right = is_odd ? (EVEN && HAS_LEFT) : !EVEN;
    if (is_pack) begin
      // dropped entries drift toward the tail, kept ones keep their order
      swap_r = mine_valid && right_valid && drop && !right_drop;
      swap_l = mine_valid && left_drop && !drop;
    end else begin
      swap_r = mine_valid && right_valid && sarl_pkg::comes_after(ent, right_ent);
      swap_l = mine_valid && sarl_pkg::comes_after(left_ent, ent);
    end
    kept = mine_valid && !drop;
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      sarl_pkg::OP_LOAD: begin
        if (sel == IW'(IDX)) begin
          ent <= ctrl.data;
          drop <= 1'b0;
        end
      end
      sarl_pkg::OP_SORT_EVEN, sarl_pkg::OP_SORT_ODD,
      sarl_pkg::OP_PACK_EVEN, sarl_pkg::OP_PACK_ODD: begin
        if (role_left && swap_r) begin
          ent <= right_ent;
          drop <= right_drop;
        end else if (role_right && swap_l) begin
          ent <= left_ent;
          drop <= left_drop;
        end
      end
      sarl_pkg::OP_MARK: begin
        drop <= mine_valid && right_valid && (ent.s <= right_ent.s) && (ent.e > right_ent.s);
      end
      sarl_pkg::OP_PROBE: begin
        lt <= ctrl.key < ent.s;
        ge <= ctrl.key >= ent.e;
      end
      sarl_pkg::OP_SELECT: begin
        pick <= (sel == IW'(IDX)) ? ent : '0;
      end
      default: begin
      end
    endcase
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned DEPTH = sarl_pkg::MAX_REGIONS_DEFAULT;
  localparam longint unsigned CYCLE_LIMIT = 3000000;
  localparam logic [sarl_pkg::ADDR_W-1:0] ADDR_MAX = '1;

  typedef struct packed {
    logic [sarl_pkg::STATUS_W-1:0] status;
    logic [sarl_pkg::ADDR_W-1:0] hs;
    logic [sarl_pkg::ADDR_W-1:0] he;
    logic [sarl_pkg::TAG_W-1:0] ht;
    logic [sarl_pkg::ENTRY_COUNT_W-1:0] cnt;
  } response_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic s_tuser = sarl_pkg::CMD_INSERT;
  logic [207:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [1:0] m_tuser;
  logic [159:0] m_tdata;

  sorted_address_range_lookup u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser), .m_tdata(m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // region table as the block should hold it
  sarl_pkg::entry_t regions[DEPTH];
  int unsigned region_count = 0;
  bit table_dirty = 0;
  response_t expected_responses[$];

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned responses_seen = 0;
  int unsigned hits_seen = 0;
  int unsigned drops_seen = 0;
  longint unsigned cycle_count = 0;

  function automatic bit ordered_after(sarl_pkg::entry_t a, sarl_pkg::entry_t b);
    if (a.s != b.s) return a.s > b.s;
    return a.e > b.e;
  endfunction

  function automatic void sort_and_merge();
    sarl_pkg::entry_t cur;
    bit drop[DEPTH];
    int j;
    int unsigned kept;
    for (int i = 1; i < region_count; i++) begin
      cur = regions[i];
      j = i;
      while (j > 0 && ordered_after(regions[j-1], cur)) begin
        regions[j] = regions[j-1];
        j--;
      end
      regions[j] = cur;
    end
    // all marks decided before any entry moves
    for (int i = 0; i < region_count; i++) begin
      drop[i] = (i + 1 < region_count) && regions[i].s <= regions[i+1].s &&
                regions[i].e > regions[i+1].s;
    end
    kept = 0;
    for (int i = 0; i < region_count; i++) begin
      if (!drop[i]) begin
        regions[kept] = regions[i];
        kept++;
      end
    end
    region_count = kept;
  endfunction

  function automatic response_t predict_response(logic cmd,
      logic [sarl_pkg::ADDR_W-1:0] s, logic [sarl_pkg::ADDR_W-1:0] e,
      logic [sarl_pkg::TAG_W-1:0] t, logic [sarl_pkg::ADDR_W-1:0] addr);
    response_t r;
    int unsigned lo, hi, mid;
    r = '{sarl_pkg::STATUS_OK, '0, '0, '0, '0};
    if (cmd == sarl_pkg::CMD_INSERT) begin
      if (region_count >= DEPTH) begin
        r.status = sarl_pkg::STATUS_FULL;
      end else begin
        regions[region_count] = '{s: s, e: e, t: t};
        region_count++;
        table_dirty = 1;
      end
    end else begin
      if (table_dirty) begin
        table_dirty = 0;
        sort_and_merge();
      end
      lo = 0;
      hi = region_count;
      r.status = sarl_pkg::STATUS_MISS;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (addr < regions[mid].s) begin
          hi = mid;
        end else if (addr >= regions[mid].e) begin
          lo = mid + 1;
        end else begin
          r.status = sarl_pkg::STATUS_OK;
          r.hs = regions[mid].s;
          r.he = regions[mid].e;
          r.ht = regions[mid].t;
          break;
        end
      end
    end
    r.cnt = region_count[sarl_pkg::ENTRY_COUNT_W-1:0];
    return r;
  endfunction

  task automatic send_request(logic cmd, logic [sarl_pkg::ADDR_W-1:0] s,
      logic [sarl_pkg::ADDR_W-1:0] e, logic [sarl_pkg::TAG_W-1:0] t,
      logic [sarl_pkg::ADDR_W-1:0] addr);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {addr, t, e, s};
    do @(posedge clk); while (!s_tready);
    expected_responses.push_back(predict_response(cmd, s, e, t, addr));
    requests_sent++;
  endtask

  task automatic insert_region(logic [sarl_pkg::ADDR_W-1:0] s,
      logic [sarl_pkg::ADDR_W-1:0] e, logic [sarl_pkg::TAG_W-1:0] t);
    send_request(sarl_pkg::CMD_INSERT, s, e, t, {$urandom, $urandom});
  endtask

  task automatic lookup_addr(logic [sarl_pkg::ADDR_W-1:0] addr);
    send_request(sarl_pkg::CMD_LOOKUP, {$urandom, $urandom}, {$urandom, $urandom},
                 sarl_pkg::TAG_W'($urandom), addr);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_responses.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [sarl_pkg::ADDR_W-1:0] pick_address();
    int unsigned k;
    k = $urandom_range(9);
    if (k < 6) return sarl_pkg::ADDR_W'($urandom_range(4095));
    if (k < 8 && region_count > 0)
      return regions[$urandom_range(region_count - 1)].s +
             sarl_pkg::ADDR_W'($urandom_range(3));
    if (k == 8) return ADDR_MAX - sarl_pkg::ADDR_W'($urandom_range(4095));
    return {$urandom, $urandom};
  endfunction

  task automatic test_directed();
    lookup_addr('0);                          // empty table
    insert_region(64'd100, 64'd200, 16'h0001);
    insert_region(64'd150, 64'd300, 16'h0002); // overlaps the end of the first
    insert_region(64'd500, 64'd500, 16'h0003); // empty region
    insert_region(64'd700, 64'd600, 16'h0004); // inverted region
    insert_region(ADDR_MAX - 64'd10, ADDR_MAX, 16'hFFFF);
    lookup_addr(64'd150);
    lookup_addr(64'd100);
    lookup_addr(64'd500);
    lookup_addr(64'd650);
    lookup_addr(ADDR_MAX - 64'd1);
    lookup_addr(ADDR_MAX);
    lookup_addr('0);
    insert_region('0, '0, '0);
    insert_region(64'd1000, 64'd2000, 16'hA5A5);
    lookup_addr(64'd299);
    lookup_addr(64'd1999);
    lookup_addr(64'd2000);
    wait_drained();
  endtask

  task automatic test_random(int unsigned items, int unsigned idle, int unsigned stall);
    logic [sarl_pkg::ADDR_W-1:0] base;
    sender_idle_pct = idle;
    receiver_stall_pct = stall;
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(1)) begin
        base = pick_address();
        if ($urandom_range(7) == 0)
          insert_region(base, {$urandom, $urandom}, sarl_pkg::TAG_W'($urandom));
        else
          insert_region(base,
                        base + sarl_pkg::ADDR_W'($urandom_range(300)) - 64'd20,
                        sarl_pkg::TAG_W'($urandom));
      end else begin
        lookup_addr(pick_address());
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_cycles = 400;
    for (int n = 0; n < 30; n++) begin
      if (n % 3 == 2) lookup_addr(pick_address());
      else insert_region(64'h1_0000 + sarl_pkg::ADDR_W'(n * 64),
                         64'h1_0000 + sarl_pkg::ADDR_W'(n * 64 + 32),
                         sarl_pkg::TAG_W'(n));
    end
    wait_drained();
  endtask

  task automatic test_full_table();
    logic [sarl_pkg::ADDR_W-1:0] base;
    sender_idle_pct = 10;
    receiver_stall_pct = 10;
    // disjoint regions so that nothing merges away
    while (region_count < DEPTH) begin
      base = 64'h8000_0000 + sarl_pkg::ADDR_W'(region_count * 32'h100);
      insert_region(base, base + 64'h80, sarl_pkg::TAG_W'($urandom));
    end
    insert_region(64'd5, 64'd9, 16'h1234);
    insert_region({$urandom, $urandom}, {$urandom, $urandom}, sarl_pkg::TAG_W'($urandom));
    for (int n = 0; n < 12; n++)
      lookup_addr(64'h8000_0000 + sarl_pkg::ADDR_W'($urandom_range(256 * 256)));
    insert_region(64'd5, 64'd9, 16'h4321);
    lookup_addr(64'd6);
    wait_drained();
  endtask

  // receiver side with random stalls and an occasional long hold
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    response_t exp_r;
    response_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser, m_tdata[63:0], m_tdata[127:64], m_tdata[143:128],
              m_tdata[152:144]};
      responses_seen++;
      if (got.status == sarl_pkg::STATUS_OK && got.cnt != 0 && got.he != 0) hits_seen++;
      if (got.status == sarl_pkg::STATUS_FULL) drops_seen++;
      if (expected_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response status=%0d", got.status);
      end else begin
        exp_r = expected_responses.pop_front();
        if (got != exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d s=%h e=%h t=%h n=%0d / got st=%0d s=%h e=%h t=%h n=%0d",
                     exp_r.status, exp_r.hs, exp_r.he, exp_r.ht, exp_r.cnt,
                     got.status, got.hs, got.he, got.ht, got.cnt);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(450, 0, 0);
    test_backpressure();
    test_random(450, 45, 0);
    test_random(450, 0, 45);
    test_random(450, 20, 20);
    test_full_table();
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (expected_responses.size() != 0) mismatches++;
    $display("%0d requests, %0d responses: inserts, merges of overlapping regions,",
             requests_sent, responses_seen);
    $display("lookups with %0d hits and a full table with %0d dropped inserts",
             hits_seen, drops_seen);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
